### hdl/lrux_pkg.sv
// Shared types and constants for the LRU cache with expiry.
package lrux_pkg;

    // Default sizes of the cache
    localparam int LRUX_ENTRIES    = 16;
    localparam int LRUX_KEY_BITS   = 32;
    localparam int LRUX_VALUE_BITS = 64;
    localparam int LRUX_TIME_BITS  = 32;

    // Fixed widths of the request and result fields
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 64;
    localparam int TTL_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 80;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_GET   = 3'd0,
        ACT_SET   = 3'd1,
        ACT_DEL   = 3'd2,
        ACT_TICK  = 3'd3,
        ACT_PURGE = 3'd4,
        ACT_CLEAR = 3'd5
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_PURGE,
        ST_HOLD
    } state_t;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_NOP,
        OP_TOUCH,
        OP_DROP_HIT,
        OP_DROP_PICK,
        OP_INSERT,
        OP_CLEAR
    } cell_op_t;

    // What the priority chain through the cells looks for
    typedef enum logic [1:0] {
        CHAIN_OFF,
        CHAIN_FREE,
        CHAIN_EXP
    } chain_mode_t;

    typedef struct packed {
        cell_op_t    op;
        chain_mode_t chain;
        logic        write;
        logic        full;
        logic        evict;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic hit_exp;
        logic pick;
    } cell_stat_t;

endpackage

### hdl/lrux_cell.sv
// One cache cell: holds an entry, its expiry and its recency rank.
module lrux_cell
    import lrux_pkg::*;
#(
    parameter int KEY_BITS   = LRUX_KEY_BITS,
    parameter int VALUE_BITS = LRUX_VALUE_BITS,
    parameter int TIME_BITS  = LRUX_TIME_BITS,
    parameter int RANK_W     = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  lookup_en,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  cell_cmd_t             cmd,
    input  logic [RANK_W-1:0]     cmd_rank,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  logic                  wr_exp_en,
    input  logic [TIME_BITS-1:0]  wr_exp_time,
    input  logic [TIME_BITS-1:0]  cur_time,
    input  logic                  chain_in,
    output logic                  chain_out,
    output cell_stat_t            stat,
    output logic [RANK_W-1:0]     rank_out,
    output logic [VALUE_BITS-1:0] value_out
);

    logic                  valid_reg, valid_next;
    logic                  hit_reg, hit_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  exp_en_reg, exp_en_next;
    logic [TIME_BITS-1:0]  exp_time_reg, exp_time_next;

    logic expired;
    logic cand;
    logic pick;
    logic lru_me;
    logic target;

    // Local status: expiry, and the priority chain that picks the lowest cell.
    always_comb
    begin
        expired = valid_reg && exp_en_reg && (cur_time > exp_time_reg);
        case (cmd.chain)
            CHAIN_FREE: cand = !valid_reg;
            CHAIN_EXP:  cand = expired;
            default:    cand = 1'b0;
        endcase
        pick      = cand && !chain_in;
        chain_out = chain_in || cand;
        lru_me    = valid_reg && (rank_reg == cmd_rank);
        target    = cmd.full ? lru_me : pick;
    end

    // Key compare is taken when the request is accepted.
    assign hit_next = lookup_en && valid_reg && (key_reg == lookup_key);

    assign stat.valid   = valid_reg;
    assign stat.hit     = hit_reg;
    assign stat.hit_exp = hit_reg && expired;
    assign stat.pick    = pick;

    assign rank_out  = (hit_reg || (pick && (cmd.chain == CHAIN_EXP))) ? rank_reg : '0;
    assign value_out = hit_reg ? value_reg : '0;

    // Next entry state for the broadcast operation.
    always_comb
    begin
        valid_next    = valid_reg;
        rank_next     = rank_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        exp_en_next   = exp_en_reg;
        exp_time_next = exp_time_reg;
        case (cmd.op)
            OP_TOUCH:
            begin
                if (hit_reg)
                begin
                    rank_next = '0;
                    if (cmd.write)
                    begin
                        value_next    = wr_value;
                        exp_en_next   = wr_exp_en;
                        exp_time_next = wr_exp_time;
                    end
                end
                else if (valid_reg && (rank_reg < cmd_rank))
                begin
                    rank_next = RANK_W'(rank_reg + 1'b1);
                end
            end
            OP_DROP_HIT:
            begin
                if (hit_reg)
                    valid_next = 1'b0;
                else if (valid_reg && (rank_reg > cmd_rank))
                    rank_next = RANK_W'(rank_reg - 1'b1);
            end
            OP_DROP_PICK:
            begin
                if (pick)
                    valid_next = 1'b0;
                else if (valid_reg && (rank_reg > cmd_rank))
                    rank_next = RANK_W'(rank_reg - 1'b1);
            end
            OP_INSERT:
            begin
                if (target)
                begin
                    valid_next    = 1'b1;
                    rank_next     = '0;
                    key_next      = wr_key;
                    value_next    = wr_value;
                    exp_en_next   = wr_exp_en;
                    exp_time_next = wr_exp_time;
                end
                else if (cmd.evict && lru_me)
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg)
                begin
                    rank_next = RANK_W'(rank_reg + 1'b1);
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        rank_reg     <= rank_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        exp_en_reg   <= exp_en_next;
        exp_time_reg <= exp_time_next;
    end

endmodule

### hdl/lru_cache_with_expiry_core.sv
// Top level of the LRU cache with expiry: request control and the row of cells.
//
// Requests arrive on the s_ stream: s_tuser carries the action (get, set,
// delete, tick, purge expired, clear) and s_tdata the key, value and ttl.
// Each request gives exactly one result on the m_ stream with the hit flag,
// read value, entry count, eviction flag and number of expired entries dropped.
// The capacity register is written through cfg_we/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. A request
// is taken only in the idle state. The key is compared in every cell as it
// is accepted; in the next cycle the cells update their ranks and the result
// is registered, so a new request is taken only once the previous one has
// finished. A purge drops one expired entry per cycle through the cell
// priority chain and finishes once the chain finds none left. Reset empties the
// cache, sets the tick count to zero and capacity to 16. When the receiver
// stalls, the result stays in the output register; one further request is
// still taken and its result waits in a hold stage, after which no request
// is accepted until the output register is free.
module lru_cache_with_expiry_core
    import lrux_pkg::*;
#(
    parameter int ENTRIES    = LRUX_ENTRIES,
    parameter int KEY_BITS   = LRUX_KEY_BITS,
    parameter int VALUE_BITS = LRUX_VALUE_BITS,
    parameter int TIME_BITS  = LRUX_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key [31:0], write_value [95:32], ttl [111:96]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action [2:0]
    input  logic [ACTION_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found [0], read_value [64:1], entry_count [69:65], evicted [70],
    // removed_count [75:71], zero [79:76]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_data
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = CNT_W + CAP_W + 1;

    state_t                state_reg, state_next;
    action_t               act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [TTL_W-1:0]      ttl_reg;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      removed_reg, removed_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] rval_reg, rval_next;
    logic                  evict_reg, evict_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  accept;
    logic                  out_free;
    logic                  lookup_en;
    action_t               in_action;
    cell_cmd_t             cmd;
    logic [RANK_W-1:0]     cmd_rank;
    logic                  wr_exp_en;
    logic [TIME_BITS-1:0]  wr_exp_time;
    logic [TIME_BITS:0]    exp_sum;
    logic [CMP_W-1:0]      cap_eff;
    logic                  ins_full;
    logic                  ins_evict;

    logic                  fin;
    logic                  f_found;
    logic [VALUE_BITS-1:0] f_rval;
    logic                  f_evict;
    logic [CNT_W-1:0]      f_removed;

    logic [ENTRIES:0]      chain;
    cell_stat_t            stat_vec [ENTRIES];
    logic [RANK_W-1:0]     rank_vec [ENTRIES];
    logic [VALUE_BITS-1:0] value_vec [ENTRIES];
    logic [ENTRIES-1:0]    hit_vec;
    logic [ENTRIES-1:0]    valid_vec;
    logic                  any_hit;
    logic                  hit_exp;
    logic [RANK_W-1:0]     rank_or;
    logic [VALUE_BITS-1:0] value_or;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic               found,
        input logic [VALUE_W-1:0] rval,
        input logic [COUNT_W-1:0] cnt,
        input logic               evict,
        input logic [COUNT_W-1:0] removed
    );
        pack_result = {4'b0000, removed, evict, cnt, rval, found};
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign in_action = action_t'(s_tuser);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Only key-based actions capture a hit in the cells.
    always_comb
    begin
        lookup_en = accept && (in_action inside {ACT_GET, ACT_SET, ACT_DEL});
    end

    // Expiry of a written entry, saturating at the top of the time range.
    always_comb
    begin
        exp_sum     = {1'b0, time_reg} + (TIME_BITS + 1)'(ttl_reg);
        wr_exp_en   = (ttl_reg != '0);
        wr_exp_time = '0;
        if (wr_exp_en)
            wr_exp_time = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
    end

    // Capacity clamped to the range one to ENTRIES.
    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_reg == '0)
            cap_eff = CMP_W'(1);
        else if (cap_eff > CMP_W'(ENTRIES))
            cap_eff = CMP_W'(ENTRIES);
        ins_full  = (count_reg == CNT_W'(ENTRIES));
        ins_evict = ins_full || ((CMP_W'(count_reg) + 1'b1) > cap_eff);
    end

    // Row of cells with the priority chain running from cell zero upward.
    assign chain[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrux_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .TIME_BITS  (TIME_BITS),
            .RANK_W     (RANK_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .lookup_en   (lookup_en),
            .lookup_key  (KEY_BITS'(s_tdata[KEY_W-1:0])),
            .cmd         (cmd),
            .cmd_rank    (cmd_rank),
            .wr_key      (key_reg),
            .wr_value    (val_reg),
            .wr_exp_en   (wr_exp_en),
            .wr_exp_time (wr_exp_time),
            .cur_time    (time_reg),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .stat        (stat_vec[i]),
            .rank_out    (rank_vec[i]),
            .value_out   (value_vec[i])
        );
    end

    // Collect hit, rank and value from the cells; at most one cell answers.
    always_comb
    begin
        any_hit  = 1'b0;
        hit_exp  = 1'b0;
        rank_or  = '0;
        value_or = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]   = stat_vec[i].hit;
            valid_vec[i] = stat_vec[i].valid;
            any_hit      = any_hit | stat_vec[i].hit;
            hit_exp      = hit_exp | stat_vec[i].hit_exp;
            rank_or      = rank_or | rank_vec[i];
            value_or     = value_or | value_vec[i];
        end
    end

    // Request sequencing, cell commands and result assembly.
    always_comb
    begin
        state_next   = state_reg;
        time_next    = time_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        rval_next    = rval_reg;
        evict_next   = evict_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        cmd          = '{op: OP_NOP, chain: CHAIN_OFF, write: 1'b0, full: 1'b0, evict: 1'b0};
        cmd_rank     = rank_or;
        fin          = 1'b0;
        f_found      = 1'b0;
        f_rval       = '0;
        f_evict      = 1'b0;
        f_removed    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                fin = 1'b1;
                case (act_reg)
                    ACT_GET:
                    begin
                        if (any_hit && hit_exp)
                        begin
                            cmd.op     = OP_DROP_HIT;
                            count_next = count_reg - 1'b1;
                            f_removed  = CNT_W'(1);
                        end
                        else if (any_hit)
                        begin
                            cmd.op  = OP_TOUCH;
                            f_found = 1'b1;
                            f_rval  = value_or;
                        end
                    end
                    ACT_SET:
                    begin
                        if (any_hit)
                        begin
                            cmd.op    = OP_TOUCH;
                            cmd.write = 1'b1;
                        end
                        else
                        begin
                            cmd.op    = OP_INSERT;
                            cmd.chain = CHAIN_FREE;
                            cmd.full  = ins_full;
                            cmd.evict = ins_evict;
                            cmd_rank  = RANK_W'(count_reg - 1'b1);
                            f_evict   = ins_evict;
                            if (!ins_evict)
                                count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_DEL:
                    begin
                        if (any_hit)
                        begin
                            cmd.op     = OP_DROP_HIT;
                            count_next = count_reg - 1'b1;
                            f_found    = 1'b1;
                        end
                    end
                    ACT_TICK:
                    begin
                        if (time_reg != '1)
                            time_next = time_reg + 1'b1;
                    end
                    ACT_PURGE:
                    begin
                        fin          = 1'b0;
                        removed_next = '0;
                        state_next   = ST_PURGE;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        count_next = '0;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_PURGE:
            begin
                // Drop the lowest expired cell each cycle until none is left.
                cmd.chain = CHAIN_EXP;
                if (chain[ENTRIES])
                begin
                    cmd.op       = OP_DROP_PICK;
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end
                else
                begin
                    fin       = 1'b1;
                    f_removed = removed_reg;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_result(found_reg, VALUE_W'(rval_reg),
                                               COUNT_W'(count_reg), evict_reg,
                                               COUNT_W'(removed_reg));
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished request goes straight out, or waits in the hold stage.
        if (fin)
        begin
            found_next   = f_found;
            rval_next    = f_rval;
            evict_next   = f_evict;
            removed_next = f_removed;
            if (out_free)
            begin
                m_valid_next = 1'b1;
                m_data_next  = pack_result(f_found, VALUE_W'(f_rval),
                                           COUNT_W'(count_next), f_evict,
                                           COUNT_W'(f_removed));
                state_next   = ST_IDLE;
            end
            else
            begin
                state_next = ST_HOLD;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            time_reg    <= time_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                cap_reg <= cfg_data;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_action;
            key_reg <= KEY_BITS'(s_tdata[KEY_W-1:0]);
            val_reg <= VALUE_BITS'(s_tdata[KEY_W+VALUE_W-1:KEY_W]);
            ttl_reg <= s_tdata[KEY_W+VALUE_W+TTL_W-1:KEY_W+VALUE_W];
        end
        removed_reg <= removed_next;
        found_reg   <= found_next;
        rval_reg    <= rval_next;
        evict_reg   <= evict_next;
        m_data_reg  <= m_data_next;
    end

`ifndef ASSERT_OFF
    // Keys are unique among live entries, so at most one cell hits.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell hit on a lookup");

    // The entry count tracks the number of live cells between requests.
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == count_reg))
        else $error("entry count differs from live cells");

    // The count never exceeds the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above cell count");

    // An accepted request is always processed in the following cycle.
    a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_UPD))
        else $error("accepted request not processed");
`endif

endmodule

### dv/lru_cache_with_expiry_core_tb.sv
// Self-checking testbench for the LRU cache with expiry core, with a built-in cache predictor.
`timescale 1ns / 1ps

module lru_cache_with_expiry_core_tb
    import lrux_pkg::*;
();

    localparam int CELLS          = LRUX_ENTRIES;
    localparam int POOL           = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_AT_RESULT = 800;
    localparam int HOLD_CYCLES    = 120;

    // Action codes that the block does not define; it must leave its state alone.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;
    localparam logic [LRUX_TIME_BITS-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [TTL_W-1:0]    ttl;
    } request_t;

    typedef struct packed {
        logic                found;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                evicted;
        logic [COUNT_W-1:0]  removed_count;
    } outcome_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // key [31:0], write_value [95:32], ttl [111:96]
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // action [2:0]
    logic [ACTION_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // found [0], read_value [64:1], entry_count [69:65], evicted [70],
    // removed_count [75:71], zero [79:76]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CAP_W-1:0]      cfg_data = '0;

    // Shadow copy of the cache contents, tick count and capacity.
    logic [KEY_W-1:0]          line_key      [CELLS];
    logic [VALUE_W-1:0]        line_value    [CELLS];
    bit                        line_live     [CELLS];
    bit                        line_ages_out [CELLS];
    logic [LRUX_TIME_BITS-1:0] line_deadline [CELLS];
    int unsigned               line_rank     [CELLS];
    logic [LRUX_TIME_BITS-1:0] tick_count   = '0;
    logic [CAP_W-1:0]          capacity_reg = CAP_RESET;

    request_t    request_q [$];
    outcome_t    outcome_q [$];
    request_t    offered;
    logic [KEY_W-1:0] key_pool [POOL];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count    = 0;
    int          results_seen  = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    lru_cache_with_expiry_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cache bookkeeping helpers.
    function automatic int live_lines();
        int n = 0;
        for (int i = 0; i < CELLS; i++)
            if (line_live[i])
                n++;
        return n;
    endfunction

    function automatic int find_line(logic [KEY_W-1:0] key);
        for (int i = 0; i < CELLS; i++)
            if (line_live[i] && line_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic bit is_stale(int i);
        return line_ages_out[i] && (tick_count > line_deadline[i]);
    endfunction

    // Remove a line and close the gap it leaves in the recency order.
    function automatic void drop_line(int i);
        int unsigned r = line_rank[i];
        line_live[i] = 1'b0;
        for (int j = 0; j < CELLS; j++)
            if (line_live[j] && line_rank[j] > r)
                line_rank[j]--;
    endfunction

    function automatic void promote_line(int i);
        int unsigned r = line_rank[i];
        for (int j = 0; j < CELLS; j++)
            if (line_live[j] && line_rank[j] < r)
                line_rank[j]++;
        line_rank[i] = 0;
    endfunction

    function automatic void drop_oldest_line();
        int oldest = -1;
        for (int j = 0; j < CELLS; j++)
            if (line_live[j] && (oldest < 0 || line_rank[j] > line_rank[oldest]))
                oldest = j;
        if (oldest >= 0)
            drop_line(oldest);
    endfunction

    // Write value and deadline; the deadline saturates at the top of the tick range.
    function automatic void store_line(int i, logic [VALUE_W-1:0] value, logic [TTL_W-1:0] ttl);
        line_value[i] = value;
        if (ttl != 0)
        begin
            line_ages_out[i] = 1'b1;
            line_deadline[i] = (LRUX_TIME_BITS'(ttl) > TICK_MAX - tick_count) ?
                               TICK_MAX : tick_count + LRUX_TIME_BITS'(ttl);
        end
        else
        begin
            line_ages_out[i] = 1'b0;
            line_deadline[i] = '0;
        end
    endfunction

    // Apply one request to the shadow cache and return the result it must produce.
    function automatic outcome_t cache_access(request_t r);
        outcome_t    o;
        int          i;
        int unsigned limit;
        o = '0;
        limit = 32'(capacity_reg);
        if (limit < 1)
            limit = 1;
        if (limit > CELLS)
            limit = CELLS;
        case (r.action)
            ACT_GET:
            begin
                i = find_line(r.key);
                if (i >= 0)
                begin
                    if (is_stale(i))
                    begin
                        drop_line(i);
                        o.removed_count = COUNT_W'(1);
                    end
                    else
                    begin
                        promote_line(i);
                        o.found = 1'b1;
                        o.read_value = line_value[i];
                    end
                end
            end
            ACT_SET:
            begin
                i = find_line(r.key);
                if (i >= 0)
                begin
                    store_line(i, r.value, r.ttl);
                    promote_line(i);
                end
                else
                begin
                    if (live_lines() >= CELLS)
                    begin
                        drop_oldest_line();
                        o.evicted = 1'b1;
                    end
                    for (i = 0; i < CELLS; i++)
                        if (!line_live[i])
                            break;
                    for (int j = 0; j < CELLS; j++)
                        if (line_live[j])
                            line_rank[j]++;
                    line_key[i] = r.key;
                    store_line(i, r.value, r.ttl);
                    line_live[i] = 1'b1;
                    line_rank[i] = 0;
                    if (!o.evicted && live_lines() > limit)
                    begin
                        drop_oldest_line();
                        o.evicted = 1'b1;
                    end
                end
            end
            ACT_DEL:
            begin
                i = find_line(r.key);
                if (i >= 0)
                begin
                    drop_line(i);
                    o.found = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (tick_count != TICK_MAX)
                    tick_count++;
            end
            ACT_PURGE:
            begin
                for (i = 0; i < CELLS; i++)
                    if (line_live[i] && is_stale(i))
                    begin
                        drop_line(i);
                        o.removed_count++;
                    end
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    line_live[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        o.entry_count = COUNT_W'(live_lines());
        return o;
    endfunction

    function automatic void push_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                                         logic [VALUE_W-1:0] value, logic [TTL_W-1:0] ttl);
        request_t r;
        r.action = action;
        r.key    = key;
        r.value  = value;
        r.ttl    = ttl;
        request_q.push_back(r);
    endfunction

    // Keys come mostly from a small pool so that hits, updates and evictions are common.
    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL - 1)] : $urandom;
        pick = $urandom_range(99);
        if (pick < 3)
            r.value = '0;
        else if (pick < 6)
            r.value = '1;
        else
            r.value = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 30)
            r.ttl = '0;
        else if (pick < 80)
            r.ttl = TTL_W'($urandom_range(12, 1));
        else if (pick < 95)
            r.ttl = TTL_W'($urandom);
        else
            r.ttl = '1;
        pick = $urandom_range(99);
        if (pick < 30)
            r.action = ACT_GET;
        else if (pick < 66)
            r.action = ACT_SET;
        else if (pick < 74)
            r.action = ACT_DEL;
        else if (pick < 88)
            r.action = ACT_TICK;
        else if (pick < 94)
            r.action = ACT_PURGE;
        else if (pick < 95)
            r.action = ACT_CLEAR;
        else if (pick < 97)
            r.action = ACT_UNUSED_6;
        else
            r.action = ACT_UNUSED_7;
        return r;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Wait until every request has gone in and every result has come out.
    // The queues and the valid flag are looked at mid-cycle, once they have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity_reg = cap;
    endtask

    task automatic run_phase(logic [CAP_W-1:0] cap, int sender_pct, int receiver_pct, int count);
        wait_drained();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        write_capacity(cap);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL; k++)
            key_pool[k] = $urandom;
        repeat (count)
            request_q.push_back(random_request());
    endtask

    // Request source: offers the next queued request and holds it until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(cache_access(offered));
            if (!s_tvalid || s_tready)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = request_q.pop_front();
                    s_tdata  <= {offered.ttl, offered.value, offered.key};
                    s_tuser  <= offered.action;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: compares each result with the oldest outstanding outcome.
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        outcome_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
                if (outcome_q.size() == 0)
                begin
                    $error("Result 0x%0h arrived with no request outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("found", VALUE_W'(want.found), VALUE_W'(m_tdata[0]));
                    check_field("read_value", want.read_value, m_tdata[64:1]);
                    check_field("entry_count", VALUE_W'(want.entry_count),
                                VALUE_W'(m_tdata[69:65]));
                    check_field("evicted", VALUE_W'(want.evicted), VALUE_W'(m_tdata[70]));
                    check_field("removed_count", VALUE_W'(want.removed_count),
                                VALUE_W'(m_tdata[75:71]));
                end
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lru_cache_with_expiry_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 75;

        // Directed part with a capacity of two, so that eviction and expiry come quickly.
        write_capacity(5'd2);
        push_request(ACT_SET, 32'h0, 64'h0, 16'h0);
        push_request(ACT_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        push_request(ACT_GET, 32'h0, {$urandom, $urandom}, 16'h0);
        push_request(ACT_SET, 32'h5, 64'h0123_4567_89AB_CDEF, 16'h1);
        push_request(ACT_GET, 32'hFFFF_FFFF, 64'h0, 16'h0);
        push_request(ACT_SET, 32'h0, 64'hA5A5_5A5A_C3C3_3C3C, 16'h0);
        repeat (2) push_request(ACT_TICK, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        // An expired hit is dropped and reported as a miss.
        push_request(ACT_GET, 32'h5, 64'h0, 16'h0);
        push_request(ACT_SET, 32'h7, 64'h1111_2222_3333_4444, 16'h1);
        push_request(ACT_SET, 32'h8, 64'h5555_6666_7777_8888, 16'h0);
        repeat (2) push_request(ACT_TICK, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        // Setting an expired key refreshes it in place.
        push_request(ACT_SET, 32'h7, 64'h9999_AAAA_BBBB_CCCC, 16'h2);
        repeat (3) push_request(ACT_TICK, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        // Delete removes an entry even after it has expired.
        push_request(ACT_DEL, 32'h7, 64'h0, 16'h0);
        push_request(ACT_DEL, 32'h7, 64'h0, 16'h0);
        push_request(ACT_SET, 32'h9, 64'hDEAD_BEEF_0000_FFFF, 16'h1);
        repeat (2) push_request(ACT_TICK, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        push_request(ACT_PURGE, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        push_request(ACT_CLEAR, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        push_request(ACT_UNUSED_6, $urandom, {$urandom, $urandom}, TTL_W'($urandom));
        push_request(ACT_UNUSED_7, $urandom, {$urandom, $urandom}, TTL_W'($urandom));

        // Random part over several capacities, zero and values above the cell count among them.
        run_phase(5'd16, 38, 75, 160);
        run_phase(5'd0, 38, 75, 120);
        run_phase(5'd31, 75, 38, 160);
        run_phase(5'd1, 75, 38, 120);
        run_phase(CAP_W'($urandom_range(15, 3)), 0, 0, 200);
        run_phase(5'd17, 0, 0, 170);

        wait_drained();
        if (fail_count == 0)
            $display("lru_cache_with_expiry_core_tb OK");
        else
            $display("lru_cache_with_expiry_core_tb NOT OK");
        $finish;
    end

endmodule

### lru_cache_with_expiry_core.f
hdl/lrux_pkg.sv
hdl/lrux_cell.sv
hdl/lru_cache_with_expiry_core.sv
dv/lru_cache_with_expiry_core_tb.sv
